### hdl/phat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phat_pkg
// shared constants, status codes and controller command type for the
// peer heartbeat aging table
// ----------------------------------------------------------------------------
package phat_pkg;

	localparam int ENTRIES_DEF  = 16;
	localparam int KEY_BITS_DEF = 64;

	localparam int KEY_W     = 64;
	localparam int AGE_W     = 4;
	localparam int STAT_W    = 2;
	localparam int CNT_OUT_W = 5;

	localparam logic [AGE_W-1:0] LIMIT_RESET = 4'd6;

	localparam logic [STAT_W-1:0] ST_NEW     = 2'd0;
	localparam logic [STAT_W-1:0] ST_REFRESH = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
	localparam logic [STAT_W-1:0] ST_TICK    = 2'd3;

	// controller to datapath commands
	typedef struct packed {
		logic capture;  // latch the incoming request
		logic eval;     // register match, free and evict vectors
		logic commit;   // update the table and load the result registers
	} cmd_t;

endpackage

### hdl/phat_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phat_ctrl
// request sequencer: capture, evaluate, commit; drives busy and done
// ----------------------------------------------------------------------------
module phat_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output logic          done,
	output phat_pkg::cmd_t cmd
);
	import phat_pkg::*;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_EVAL   = 2'd1;
	localparam logic [1:0] S_COMMIT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_n;
	logic       accept;
	logic       done_q;

	assign busy   = (state_q == S_EVAL);
	assign accept = start && !busy;

	always_comb begin
		case (state_q)
			S_IDLE:   state_n = accept ? S_EVAL : S_IDLE;
			S_EVAL:   state_n = S_COMMIT;
			S_COMMIT: state_n = accept ? S_EVAL : S_IDLE;
			default:  state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			done_q  <= (state_q == S_COMMIT);
		end
	end

	assign cmd.capture = accept;
	assign cmd.eval    = (state_q == S_EVAL);
	assign cmd.commit  = (state_q == S_COMMIT);
	assign done        = done_q;

endmodule

### hdl/phat_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phat_datapath
// entry table with per-entry key compare lanes, aging logic, live counter
// and result registers
// ----------------------------------------------------------------------------
module phat_datapath #(
	parameter int ENTRIES  = phat_pkg::ENTRIES_DEF,
	parameter int KEY_BITS = phat_pkg::KEY_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  phat_pkg::cmd_t                 cmd,
	input  logic                           req_type,
	input  logic [phat_pkg::KEY_W-1:0]     peer_key,
	input  logic                           cfg_we,
	input  logic [phat_pkg::AGE_W-1:0]     cfg_wdata,
	output logic [phat_pkg::STAT_W-1:0]    status,
	output logic [phat_pkg::CNT_OUT_W-1:0] evicted_count,
	output logic [phat_pkg::CNT_OUT_W-1:0] live_count
);
	import phat_pkg::*;

	localparam int CNT_W = $clog2(ENTRIES + 1);

	// table
	logic [ENTRIES-1:0]  valid_q;
	logic [AGE_W-1:0]    age_q [ENTRIES];
	logic [KEY_BITS-1:0] key_q [ENTRIES];
	logic [CNT_W-1:0]    live_q;
	logic [AGE_W-1:0]    limit_q;

	// captured request
	logic                tick_q;
	logic [KEY_BITS-1:0] req_key_q;

	// evaluation stage
	logic [ENTRIES-1:0] hit_vec, evict_vec;
	logic [ENTRIES-1:0] hit_s1, free_s1, evict_s1;
	logic [ENTRIES-1:0] hit_oh, free_oh;
	logic               hit_any, free_any;
	logic [CNT_W-1:0]   evicted_n;
	logic [CNT_W-1:0]   live_n;
	logic [STAT_W-1:0]  stat_n;

	// result registers
	logic [STAT_W-1:0]    status_q;
	logic [CNT_OUT_W-1:0] evicted_q;
	logic [CNT_OUT_W-1:0] live_out_q;

	// compare lanes, one per entry
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			hit_vec[i]   = valid_q[i] && (key_q[i] == req_key_q);
			evict_vec[i] = valid_q[i] && (age_q[i] >= limit_q);
		end
	end

	// lowest set bit picks the entry
	assign hit_oh    = hit_s1 & (~hit_s1 + ENTRIES'(1));
	assign free_oh   = free_s1 & (~free_s1 + ENTRIES'(1));
	assign hit_any   = |hit_s1;
	assign free_any  = |free_s1;
	assign evicted_n = CNT_W'($countones(evict_s1));

	always_comb begin
		if (tick_q) begin
			stat_n = ST_TICK;
			live_n = live_q - evicted_n;
		end else if (hit_any) begin
			stat_n = ST_REFRESH;
			live_n = live_q;
		end else if (free_any) begin
			stat_n = ST_NEW;
			live_n = live_q + CNT_W'(1);
		end else begin
			stat_n = ST_FULL;
			live_n = live_q;
		end
	end

	// miss limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	// request capture and evaluation stage
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			tick_q    <= req_type;
			req_key_q <= peer_key[KEY_BITS-1:0];
		end
		if (cmd.eval) begin
			hit_s1   <= hit_vec;
			free_s1  <= ~valid_q;
			evict_s1 <= evict_vec;
		end
	end

	// valid bits, ages and live count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			live_q  <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				age_q[i] <= '0;
			end
		end else if (cmd.commit) begin
			live_q <= live_n;
			if (tick_q) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (evict_s1[i]) begin
						valid_q[i] <= 1'b0;
						age_q[i]   <= '0;
					end else if (valid_q[i]) begin
						age_q[i] <= age_q[i] + AGE_W'(1);
					end
				end
			end else if (hit_any) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (hit_oh[i]) begin
						age_q[i] <= '0;
					end
				end
			end else begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (free_oh[i]) begin
						valid_q[i] <= 1'b1;
						age_q[i]   <= '0;
					end
				end
			end
		end
	end

	// keys, written on allocation only
	always_ff @(posedge clk) begin
		if (cmd.commit && !tick_q && !hit_any) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (free_oh[i]) begin
					key_q[i] <= req_key_q;
				end
			end
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q   <= stat_n;
			evicted_q  <= tick_q ? CNT_OUT_W'(evicted_n) : '0;
			live_out_q <= CNT_OUT_W'(live_n);
		end
	end

	assign status        = status_q;
	assign evicted_count = evicted_q;
	assign live_count    = live_out_q;

endmodule

### hdl/peer_heartbeat_aging_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// peer_heartbeat_aging_table
// liveness table of registered peers with register/refresh and aging ticks
// ----------------------------------------------------------------------------
// A request is taken at a rising edge with start high and busy low. Each
// request gives exactly one result, shown for one cycle with done high
// after the accept edge, the compare cycle and the commit cycle. The
// receiver cannot stall: a result must be taken in its done cycle. busy is
// high only in the compare cycle, so a new request can be taken in the
// commit cycle, before the result of the last one is shown; the compare
// stage is registered and followed by the table update. A register request
// (req_type 0) looks up peer_key among the valid entries; a hit resets that
// entry's age (status refresh), a miss fills the lowest free entry (status
// new) or is refused when the table is full. A tick (req_type 1) evicts
// every valid entry whose age is at or above miss_limit and ages the rest
// by one. Only the low KEY_BITS bits of peer_key are stored and compared.
// The user must write miss_limit (reset value 6) through cfg_we / cfg_wdata
// only while no request is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
module peer_heartbeat_aging_table #(
	parameter int ENTRIES  = phat_pkg::ENTRIES_DEF,
	parameter int KEY_BITS = phat_pkg::KEY_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// request channel
	input  logic                           start,
	output logic                           busy,
	input  logic                           req_type,
	input  logic [phat_pkg::KEY_W-1:0]     peer_key,
	// miss limit register
	input  logic                           cfg_we,
	input  logic [phat_pkg::AGE_W-1:0]     cfg_wdata,
	// result channel
	output logic                           done,
	output logic [phat_pkg::STAT_W-1:0]    status,
	output logic [phat_pkg::CNT_OUT_W-1:0] evicted_count,
	output logic [phat_pkg::CNT_OUT_W-1:0] live_count
);
	import phat_pkg::*;

	cmd_t cmd;

	// sequencer: idle -> compare -> commit
	phat_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// table, compare lanes, counters and result registers
	phat_datapath #(
		.ENTRIES  (ENTRIES),
		.KEY_BITS (KEY_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.req_type      (req_type),
		.peer_key      (peer_key),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.status        (status),
		.evicted_count (evicted_count),
		.live_count    (live_count)
	);

endmodule

### hdl/phat_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phat_checker
// port-level timing checks for the peer heartbeat aging table
// ----------------------------------------------------------------------------
module phat_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           start,
	input logic                           busy,
	input logic                           done,
	input logic [phat_pkg::STAT_W-1:0]    status,
	input logic [phat_pkg::CNT_OUT_W-1:0] evicted_count
);
	import phat_pkg::*;

	// an accepted request raises busy in the next cycle, holding off the next one
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accepted request");

	// busy lasts a single cycle
	a_busy_single: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("busy held longer than one cycle");

	// fixed latency from request to result
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done)
		else $error("result strobe missing three cycles after request");

	// register requests never report evictions
	a_no_evict_on_reg: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != ST_TICK)) |-> (evicted_count == '0))
		else $error("nonzero evicted count on register result");

endmodule

bind peer_heartbeat_aging_table phat_checker u_phat_checker (.*);
